[rtl/pld_pkg.sv]
// Shared types and constants for the polyline point densifier.
package pld_pkg;

   localparam int COORD_W     = 9;
   localparam int EXTENT_W    = 10;
   localparam int THR_W       = 7;
   localparam int THRESH_DIV  = 10;
   // x/10 == (x*205) >> 11 for every x below 1029
   localparam int RECIP_W     = 8;
   localparam int RECIP_10    = 205;
   localparam int RECIP_SHIFT = 11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQUARE,
      ST_SETUP,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_RUN,
      ST_LAST
   } state_type;

   typedef struct packed {
      logic load;
      logic diff;
      logic square;
      logic setup;
      logic div_start;
      logic step_init;
      logic emit_mid;
      logic emit_last;
   } cmd_type;

   typedef struct packed {
      logic interp;
      logic in_run;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

[rtl/pld_if.sv]
// Channel interfaces: point input, point result and configuration write.
interface pld_req_if;
   logic                          valid;
   logic                          ready;
   logic [pld_pkg::COORD_W-1:0]   x_coord;
   logic [pld_pkg::COORD_W-1:0]   y_coord;
   logic                          stroke_start;

   modport source (output valid, x_coord, y_coord, stroke_start, input ready);
   modport sink   (input valid, x_coord, y_coord, stroke_start, output ready);
endinterface

interface pld_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pld_pkg::COORD_W-1:0]   point_x;
   logic [pld_pkg::COORD_W-1:0]   point_y;
   logic                          last_of_run;

   modport source (output valid, point_x, point_y, last_of_run, input ready);
   modport sink   (input valid, point_x, point_y, last_of_run, output ready);
endinterface

interface pld_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pld_pkg::EXTENT_W-1:0]  map_extent;

   modport source (output valid, map_extent, input ready);
   modport sink   (input valid, map_extent, output ready);
endinterface

[rtl/pld_div.sv]
// Restoring divider, one quotient bit per cycle.
module pld_div #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den};
      ge      = shifted >= {1'b0, den};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = num;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

[rtl/pld_ctrl.sv]
// Sequencer for one input point: distance test, slope division, point sweep.
module pld_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pld_pkg::stat_type stat,
   output pld_pkg::cmd_type  cmd
);

   pld_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pld_pkg::ST_IDLE:     if (req_valid) state_in = pld_pkg::ST_DIFF;
         pld_pkg::ST_DIFF:     state_in = pld_pkg::ST_SQUARE;
         pld_pkg::ST_SQUARE:   state_in = pld_pkg::ST_SETUP;
         pld_pkg::ST_SETUP: begin
            state_in = stat.interp ? pld_pkg::ST_DIV_LOAD : pld_pkg::ST_LAST;
         end
         pld_pkg::ST_DIV_LOAD: state_in = pld_pkg::ST_DIVIDE;
         pld_pkg::ST_DIVIDE:   if (stat.div_done) state_in = pld_pkg::ST_RUN;
         pld_pkg::ST_RUN:      if (!stat.in_run) state_in = pld_pkg::ST_LAST;
         pld_pkg::ST_LAST:     if (stat.out_free) state_in = pld_pkg::ST_IDLE;
         default:              state_in = pld_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pld_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         pld_pkg::ST_DIFF:     cmd.diff = 1'b1;
         pld_pkg::ST_SQUARE:   cmd.square = 1'b1;
         pld_pkg::ST_SETUP:    cmd.setup = 1'b1;
         pld_pkg::ST_DIV_LOAD: cmd.div_start = 1'b1;
         pld_pkg::ST_DIVIDE:   cmd.step_init = stat.div_done;
         pld_pkg::ST_RUN:      cmd.emit_mid = stat.in_run && stat.out_free;
         pld_pkg::ST_LAST:     cmd.emit_last = stat.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pld_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/pld_dp.sv]
// Datapath: previous point, distance threshold, sweep registers, result register.
module pld_dp #(
   parameter int MAP_SIZE  = 512,
   parameter int STEP_SIZE = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pld_pkg::cmd_type                cmd,
   output pld_pkg::stat_type               stat,
   input  logic [pld_pkg::COORD_W-1:0]     req_x_coord,
   input  logic [pld_pkg::COORD_W-1:0]     req_y_coord,
   input  logic                            req_stroke_start,
   input  logic                            csr_valid,
   input  logic [pld_pkg::EXTENT_W-1:0]    csr_map_extent,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pld_pkg::COORD_W-1:0]     rsp_point_x,
   output logic [pld_pkg::COORD_W-1:0]     rsp_point_y,
   output logic                            rsp_last_of_run
);

   localparam int CW        = pld_pkg::COORD_W;
   localparam int SW        = CW + 1;
   localparam int SQ_W      = 2 * CW;
   localparam int STEP_W    = $clog2(STEP_SIZE + 1);
   localparam int NUM_W     = CW + STEP_W;
   localparam int PROD_W    = pld_pkg::EXTENT_W + pld_pkg::RECIP_W;
   localparam int THR_RESET = MAP_SIZE / pld_pkg::THRESH_DIV;
   localparam logic [SW-1:0] STEP_S = SW'(STEP_SIZE);

   // input point and history
   logic [CW-1:0]  cur_x_ff, cur_y_ff, prev_x_ff, prev_y_ff;
   logic           start_ff, have_prev_ff;
   logic [pld_pkg::THR_W-1:0] thr_ff, thr_in;
   logic [PROD_W-1:0]         thr_prod;

   // distance
   logic signed [SW-1:0] dx_ff, dy_ff;
   logic [CW-1:0]        adx, ady;
   logic [SQ_W-1:0]      dx2_ff, dy2_ff;
   logic [SQ_W:0]        dist_sq;

   // sweep setup
   logic                 steep, vert, cur_low, neg_in;
   logic signed [SW-1:0] dmin_raw;
   logic [SW-1:0]        amin_full;
   logic [CW-1:0]        lm_in, hm_in, lmin_in, d_in;
   logic [NUM_W-1:0]     num_in;
   logic [CW-1:0]        hm_ff, lmin_ff, d_ff;
   logic [NUM_W-1:0]     num_ff;
   logic                 neg_ff, steep_ff;
   logic [SW-1:0]        s_ff, s_in;
   logic [SW-1:0]        q_ff, q_in;
   logic [CW-1:0]        r_ff, r_in;

   // divider
   logic                 div_done;
   logic [NUM_W-1:0]     div_quo;
   logic [CW-1:0]        div_rem;
   logic [SW-1:0]        qi;

   // per-point arithmetic
   logic [SW-1:0]        r_sum, r_wrap, r2, qr, minor;
   logic                 wrap, round_up;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]        out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                 out_last_ff, out_last_in;

   pld_div #(
      .NUM_W (NUM_W),
      .DEN_W (CW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (d_ff),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // the per-step quotient never exceeds STEP_SIZE
   assign qi = div_quo[SW-1:0];

   always_comb begin
      thr_prod = PROD_W'(csr_map_extent) * PROD_W'(pld_pkg::RECIP_10);
      thr_in   = thr_prod[pld_pkg::RECIP_SHIFT +: pld_pkg::THR_W];
   end

   always_comb begin
      adx     = dx_ff[SW-1] ? CW'(-dx_ff) : dx_ff[CW-1:0];
      ady     = dy_ff[SW-1] ? CW'(-dy_ff) : dy_ff[CW-1:0];
      dist_sq = {1'b0, dx2_ff} + {1'b0, dy2_ff};

      steep    = ady > adx;
      vert     = dx_ff == '0;
      cur_low  = steep ? (dy_ff > 0) : (dx_ff > 0);
      dmin_raw = steep ? dx_ff : dy_ff;
      if (steep) begin
         lm_in   = cur_low ? cur_y_ff : prev_y_ff;
         hm_in   = cur_low ? prev_y_ff : cur_y_ff;
         lmin_in = cur_low ? cur_x_ff : prev_x_ff;
         d_in    = ady;
      end else begin
         lm_in   = cur_low ? cur_x_ff : prev_x_ff;
         hm_in   = cur_low ? prev_x_ff : cur_x_ff;
         lmin_in = cur_low ? cur_y_ff : prev_y_ff;
         d_in    = adx;
      end
      // minor delta runs from the low end to the high end
      neg_in    = cur_low ? (dmin_raw < 0) : (dmin_raw > 0);
      amin_full = dmin_raw[SW-1] ? SW'(-dmin_raw) : SW'(dmin_raw);
      num_in    = NUM_W'(amin_full[CW-1:0]) * NUM_W'(STEP_SIZE);
      // a vertical sweep starts on its low end
      s_in      = {1'b0, lm_in} + (vert ? SW'(0) : STEP_S);
   end

   always_comb begin
      r2       = {r_ff, 1'b0};
      round_up = (r2 > {1'b0, d_ff}) || ((r2 == {1'b0, d_ff}) && q_ff[0]);
      qr       = q_ff + SW'(round_up);
      minor    = neg_ff ? ({1'b0, lmin_ff} - qr) : ({1'b0, lmin_ff} + qr);
      r_sum    = {1'b0, r_ff} + {1'b0, div_rem};
      wrap     = r_sum >= {1'b0, d_ff};
      r_wrap   = r_sum - {1'b0, d_ff};
   end

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      if (cmd.step_init) begin
         q_in = qi;
         r_in = div_rem;
      end else if (cmd.emit_mid) begin
         // advance the exact ratio by one step, remainder kept below the divisor
         q_in = q_ff + qi + SW'(wrap);
         r_in = wrap ? r_wrap[CW-1:0] : r_sum[CW-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit_mid) begin
         rsp_valid_in = 1'b1;
         out_last_in  = 1'b0;
         out_x_in     = steep_ff ? minor[CW-1:0] : s_ff[CW-1:0];
         out_y_in     = steep_ff ? s_ff[CW-1:0] : minor[CW-1:0];
      end else if (cmd.emit_last) begin
         rsp_valid_in = 1'b1;
         out_last_in  = 1'b1;
         out_x_in     = cur_x_ff;
         out_y_in     = cur_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         thr_ff       <= pld_pkg::THR_W'(THR_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            thr_ff <= thr_in;
         end
         if (cmd.emit_last) begin
            have_prev_ff <= 1'b1;
            prev_x_ff    <= cur_x_ff;
            prev_y_ff    <= cur_y_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff <= req_x_coord;
         cur_y_ff <= req_y_coord;
         start_ff <= req_stroke_start;
      end
      if (cmd.diff) begin
         dx_ff <= $signed({1'b0, prev_x_ff}) - $signed({1'b0, cur_x_ff});
         dy_ff <= $signed({1'b0, prev_y_ff}) - $signed({1'b0, cur_y_ff});
      end
      if (cmd.square) begin
         dx2_ff <= SQ_W'(adx) * SQ_W'(adx);
         dy2_ff <= SQ_W'(ady) * SQ_W'(ady);
      end
      if (cmd.setup) begin
         hm_ff    <= hm_in;
         lmin_ff  <= lmin_in;
         d_ff     <= d_in;
         num_ff   <= num_in;
         neg_ff   <= neg_in;
         steep_ff <= steep;
      end
      if (cmd.setup || cmd.emit_mid) begin
         s_ff <= cmd.setup ? s_in : s_ff + STEP_S;
      end
      q_ff        <= q_in;
      r_ff        <= r_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      stat.interp   = have_prev_ff && !start_ff &&
                      (dist_sq > (SQ_W + 1)'(thr_ff));
      stat.in_run   = s_ff <= {1'b0, hm_ff};
      stat.div_done = div_done;
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = out_x_ff;
   assign rsp_point_y     = out_y_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

[rtl/polyline_point_densifier.sv]
// Top level of the polyline point densifier.
//
//   channel | dir | transfer when       | payload
//   req_bus | in  | valid && ready      | x_coord, y_coord, stroke_start
//   rsp_bus | out | valid && ready      | point_x, point_y, last_of_run
//   csr_bus | in  | valid (ready high)  | map_extent
//
// A point with no sweep passes the difference, square and setup states and is
// then written into the output register from the last state.
// A sweep adds the slope divider, with NUM_W quotient bits, and the end of the run
// (NUM_W = 9 + bits of STEP_SIZE, 13 at the default), and emits one inserted
// point per cycle while rsp_bus does not stall; stalls on rsp_bus hold the sweep.
// req_bus takes the next point once the last result is in the output
// register. Reset is synchronous; no clearing pass follows it.
module polyline_point_densifier #(
   parameter int MAP_SIZE  = 512,
   parameter int STEP_SIZE = 10
) (
   input  logic  clock,
   input  logic  reset,
   pld_req_if.sink   req_bus,
   pld_rsp_if.source rsp_bus,
   pld_csr_if.sink   csr_bus
);

   pld_pkg::cmd_type  cmd;
   pld_pkg::stat_type stat;

   assign csr_bus.ready = 1'b1;

   pld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pld_dp #(
      .MAP_SIZE  (MAP_SIZE),
      .STEP_SIZE (STEP_SIZE)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_x_coord      (req_bus.x_coord),
      .req_y_coord      (req_bus.y_coord),
      .req_stroke_start (req_bus.stroke_start),
      .csr_valid        (csr_bus.valid),
      .csr_map_extent   (csr_bus.map_extent),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_point_x      (rsp_bus.point_x),
      .rsp_point_y      (rsp_bus.point_y),
      .rsp_last_of_run  (rsp_bus.last_of_run)
   );

endmodule

[rtl/pld_chk.sv]
// Port checker for the polyline point densifier, bound to the top level.
module pld_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pld_pkg::COORD_W-1:0]   rsp_point_x,
   input logic [pld_pkg::COORD_W-1:0]   rsp_point_y,
   input logic                          rsp_last_of_run,
   input logic                          csr_ready
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_y) &&
         $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // one point at a time: input closes right after a transfer
   a_req_close: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input open right after a transfer");

   // inserted points belong to a run still in progress
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("input open while an inserted point is pending");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port not ready");

endmodule

bind polyline_point_densifier pld_chk u_pld_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_point_x     (rsp_bus.point_x),
   .rsp_point_y     (rsp_bus.point_y),
   .rsp_last_of_run (rsp_bus.last_of_run),
   .csr_ready       (csr_bus.ready)
);

[dv/polyline_point_densifier_tb.sv]
// Self-checking testbench for polyline_point_densifier: directed and random strokes.
module polyline_point_densifier_tb;

   localparam int STEP      = 10;
   localparam int COORD_MAX = (1 << pld_pkg::COORD_W) - 1;

   typedef struct packed {
      logic [pld_pkg::COORD_W-1:0] px;
      logic [pld_pkg::COORD_W-1:0] py;
      logic                        is_last;
   } dense_point_type;

   logic clock;
   logic reset;

   pld_req_if req_bus();
   pld_rsp_if rsp_bus();
   pld_csr_if csr_bus();

   polyline_point_densifier DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor state
   logic [pld_pkg::EXTENT_W-1:0] extent_now;
   int                           last_x;
   int                           last_y;
   bit                           have_last;
   dense_point_type              due_points[$];

   int mismatch_count;
   int req_idle_pct;
   int rsp_idle_pct;
   int hold_off_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      #20_000_000;
      $display("polyline_point_densifier_tb: done, errors");
      $finish;
   end

   function automatic int clamp_coord(int v);
      return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
   endfunction

   function automatic int div_round_even(int n, int d);
      int a, q, r;
      a = (n < 0) ? -n : n;
      q = a / d;
      r = a % d;
      if (2 * r > d || (2 * r == d && q[0]))
         q++;
      return (n < 0) ? -q : q;
   endfunction

   function automatic void push_point(int x, int y, bit is_last);
      dense_point_type p;
      p.px       = pld_pkg::COORD_W'(x);
      p.py       = pld_pkg::COORD_W'(y);
      p.is_last  = is_last;
      due_points = {due_points, p};
   endfunction

   // Queue every point that one accepted input produces.
   function automatic void densify_point(int x, int y, bit start);
      int dx, dy, adx, ady, sq_dist, thr, s, lx, ly, hx, hy;
      if (!start && have_last) begin
         dx      = last_x - x;
         dy      = last_y - y;
         sq_dist = dx * dx + dy * dy;
         thr     = int'(extent_now) / pld_pkg::THRESH_DIV;
         adx     = (dx < 0) ? -dx : dx;
         ady     = (dy < 0) ? -dy : dy;
         if (sq_dist > thr) begin
            if (dx == 0) begin
               lx = (y < last_y) ? y : last_y;
               hx = (y < last_y) ? last_y : y;
               for (s = lx; s <= hx; s += STEP)
                  push_point(x, s, 1'b0);
            end else if (ady <= adx) begin
               if (x < last_x) begin
                  lx = x;      ly = y;      hx = last_x; hy = last_y;
               end else begin
                  lx = last_x; ly = last_y; hx = x;      hy = y;
               end
               for (s = lx + STEP; s <= hx; s += STEP)
                  push_point(s, ly + div_round_even((hy - ly) * (s - lx), hx - lx), 1'b0);
            end else begin
               if (y < last_y) begin
                  lx = x;      ly = y;      hx = last_x; hy = last_y;
               end else begin
                  lx = last_x; ly = last_y; hx = x;      hy = y;
               end
               for (s = ly + STEP; s <= hy; s += STEP)
                  push_point(lx + div_round_even((hx - lx) * (s - ly), hy - ly), s, 1'b0);
            end
         end
      end
      push_point(x, y, 1'b1);
      last_x    = x;
      last_y    = y;
      have_last = 1'b1;
   endfunction

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin : rsp_throttle
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Compare each result transfer with the oldest queued point.
   always @(posedge clock) begin
      dense_point_type exp_pt;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_points.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time,
                     rsp_bus.point_x, rsp_bus.point_y, rsp_bus.last_of_run);
         end else begin
            exp_pt = due_points.pop_front();
            if (rsp_bus.point_x !== exp_pt.px) begin
               mismatch_count++;
               $display("%0t: point_x expected %0d, got %0d", $time,
                        exp_pt.px, rsp_bus.point_x);
            end
            if (rsp_bus.point_y !== exp_pt.py) begin
               mismatch_count++;
               $display("%0t: point_y expected %0d, got %0d", $time,
                        exp_pt.py, rsp_bus.point_y);
            end
            if (rsp_bus.last_of_run !== exp_pt.is_last) begin
               mismatch_count++;
               $display("%0t: last_of_run expected %0b, got %0b", $time,
                        exp_pt.is_last, rsp_bus.last_of_run);
            end
         end
      end
   end

   task automatic send_point(input int x, input int y, input bit start);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.x_coord      <= pld_pkg::COORD_W'(x);
      req_bus.y_coord      <= pld_pkg::COORD_W'(y);
      req_bus.stroke_start <= start;
      do @(posedge clock); while (!req_bus.ready);
      densify_point(x, y, start);
   endtask

   // Stop offering points, then hold until every queued point has come out.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (due_points.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_extent(input logic [pld_pkg::EXTENT_W-1:0] value);
      csr_bus.valid      <= 1'b1;
      csr_bus.map_extent <= value;
      do @(posedge clock); while (!csr_bus.ready);
      extent_now = value;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic test_directed();
      send_point(300, 200, 1'b0);   // no previous point yet
      send_point(5, 0, 1'b1);
      send_point(5, 511, 1'b0);     // longest vertical run
      send_point(5, 100, 1'b0);     // vertical, going down
      send_point(5, 200, 1'b0);     // vertical, step lands on high end
      send_point(0, 0, 1'b1);
      send_point(511, 511, 1'b0);   // longest diagonal
      send_point(491, 510, 1'b0);   // half-way tie rounds to even
      send_point(511, 507, 1'b0);   // negative tie, last insert hits new point
      send_point(510, 487, 1'b0);   // steep with tie
      send_point(505, 482, 1'b0);   // inside threshold
      send_point(505, 482, 1'b0);   // same point again
      wait_drained();
      write_extent(10'd500);
      send_point(498, 481, 1'b0);   // distance equals threshold
      send_point(491, 479, 1'b0);   // just over, nothing to insert
      send_point(0, 511, 1'b0);
      send_point(511, 0, 1'b0);
      send_point(256, 255, 1'b1);
      send_point(0, 0, 1'b0);
      send_point(3, 400, 1'b0);     // steep, positive slope
      send_point(511, 397, 1'b0);
      wait_drained();
   endtask

   task automatic test_extent_settings();
      logic [pld_pkg::EXTENT_W-1:0] settings[5];
      int cx, cy, i, k;
      settings = '{10'd0, 10'd1, 10'd1023, 10'd37, 10'd512};
      for (k = 0; k < 5; k++) begin
         wait_drained();
         write_extent(settings[k]);
         cx = $urandom_range(COORD_MAX);
         cy = $urandom_range(COORD_MAX);
         send_point(cx, cy, 1'b1);
         for (i = 0; i < 11; i++) begin
            cx = clamp_coord(cx + int'($urandom_range(22)) - 11);
            cy = clamp_coord(cy + int'($urandom_range(22)) - 11);
            send_point(cx, cy, 1'b0);
         end
      end
      wait_drained();
   endtask

   // Strokes: a point that is mostly a stroke start, then a run of moves mostly short, some long.
   task automatic test_random_strokes(input int n_items);
      int sent, len, i, kind, cx, cy;
      bit start;
      sent = 0;
      while (sent < n_items) begin
         cx = $urandom_range(COORD_MAX);
         cy = $urandom_range(COORD_MAX);
         send_point(cx, cy, $urandom_range(9) != 0);
         sent++;
         len = $urandom_range(8, 1);
         for (i = 0; i < len && sent < n_items; i++) begin
            kind  = $urandom_range(99);
            start = 1'b0;
            if (kind < 55) begin
               cx = clamp_coord(cx + int'($urandom_range(24)) - 12);
               cy = clamp_coord(cy + int'($urandom_range(24)) - 12);
            end else if (kind < 78) begin
               cx = clamp_coord(cx + int'($urandom_range(120)) - 60);
               cy = clamp_coord(cy + int'($urandom_range(120)) - 60);
            end else if (kind < 88) begin
               if ($urandom_range(1))
                  cy = $urandom_range(COORD_MAX);
               else
                  cx = $urandom_range(COORD_MAX);
            end else if (kind < 95) begin
               cx = $urandom_range(COORD_MAX);
               cy = $urandom_range(COORD_MAX);
            end else begin
               cx = clamp_coord(cx + int'($urandom_range(40)) - 20);
               cy = clamp_coord(cy + int'($urandom_range(40)) - 20);
               start = 1'b1;
            end
            send_point(cx, cy, start);
            sent++;
         end
      end
   endtask

   // Hold the receiver off so the block fills and stalls its input.
   task automatic test_backpressure();
      wait_drained();
      hold_off_left = 250;
      test_random_strokes(20);
      wait_drained();
   endtask

   task automatic test_drain_pause();
      int k;
      for (k = 0; k < 3; k++) begin
         test_random_strokes(8);
         wait_drained();
      end
   endtask

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.x_coord      <= '0;
      req_bus.y_coord      <= '0;
      req_bus.stroke_start <= 1'b0;
      csr_bus.valid        <= 1'b0;
      csr_bus.map_extent   <= '0;
      extent_now     = 10'd512;
      last_x         = 0;
      last_y         = 0;
      have_last      = 1'b0;
      mismatch_count = 0;
      hold_off_left  = 0;
      req_idle_pct   = 23;
      rsp_idle_pct   = 77;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_extent_settings();
      test_random_strokes(75);
      wait_drained();
      req_idle_pct = 77;
      rsp_idle_pct = 23;
      test_random_strokes(75);
      wait_drained();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_strokes(70);
      test_backpressure();
      req_idle_pct = 23;
      rsp_idle_pct = 77;
      test_drain_pause();
      wait_drained();

      if (mismatch_count == 0)
         $display("polyline_point_densifier_tb: done, clean");
      else
         $display("polyline_point_densifier_tb: done, errors");
      $finish;
   end

endmodule
